// File: hw/rtl/skq_pkg.sv
// shared constants for the sorted key queue
// used by the top level and its checker, no dependencies
package skq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 7;

	// request codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: hw/rtl/sorted_key_queue_top.sv
// sorted key queue: circular entry memory with insertion walk and head pop
// one request at a time; a pop reads the head, takes it in S_POP and reports
//   in S_FIN; an insert walks down one entry per cycle through the single
//   entry memory port pair, moving up entries whose key is not below the new
//   key and writing the new entry; full inserts and pops on empty go to S_FIN
// reset clears count, head pointer, control and output valid; memory is not cleared
// depends on skq_pkg
module sorted_key_queue_top
	import skq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic signed [KEY_W-1:0]    item_key,
	input  logic [PAY_W-1:0]           item_payload,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic signed [KEY_W-1:0]    popped_key,
	output logic [PAY_W-1:0]           popped_payload,
	output logic [COUNT_OUT_W-1:0]     entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_W + PAY_W;
	localparam logic [CW:0] CAP_W = (CW+1)'(CAPACITY);
	localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_PLACE,
		S_POP,
		S_FIN
	} state_t;

	state_t state_q;

	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rdata_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] rem_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [KEY_W-1:0] res_key_q;
	logic [PAY_W-1:0] res_pay_q;

	logic out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0] popped_key_q;
	logic [PAY_W-1:0] popped_payload_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;

	logic accept;
	logic full;
	logic empty;
	logic [CW:0] tail_sum;
	logic [AW-1:0] tail;
	logic shift;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST : p - AW'(1);
	endfunction

	// request handshake and queue status
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);

	// physical slot one past the last stored entry
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	always_comb begin
		if (tail_sum >= CAP_W) begin
			tail = AW'(tail_sum - CAP_W);
		end else begin
			tail = AW'(tail_sum);
		end
	end

	// walked entry moves up when its key is not below the new key
	assign shift = ($signed(rdata_q[EW-1:PAY_W]) >= key_q);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q;
		wr_en   = 1'b0;
		wr_addr = wr_ptr_q;
		wr_data = {key_q, pay_q};
		case (state_q)
			S_IDLE: begin
				if (accept && !empty) begin
					if (command == CMD_INSERT && !full) begin
						rd_en   = 1'b1;
						rd_addr = ptr_dec(tail);
					end else if (command == CMD_POP) begin
						rd_en   = 1'b1;
						rd_addr = head_q;
					end
				end
			end
			S_WALK: begin
				wr_en = 1'b1;
				if (shift) begin
					wr_data = rdata_q;
					if (rem_q > CW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = ptr_dec(rd_ptr_q);
					end
				end
			end
			S_PLACE: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q        <= item_key;
						pay_q        <= item_payload;
						res_status_q <= ST_OK;
						res_key_q    <= '0;
						res_pay_q    <= '0;
						if (command == CMD_INSERT) begin
							if (full) begin
								res_status_q <= ST_FULL;
								state_q      <= S_FIN;
							end else if (empty) begin
								wr_ptr_q <= tail;
								state_q  <= S_PLACE;
							end else begin
								rd_ptr_q <= ptr_dec(tail);
								wr_ptr_q <= tail;
								rem_q    <= count_q;
								state_q  <= S_WALK;
							end
						end else begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_POP;
							end
						end
					end
				end
				S_WALK: begin
					if (shift) begin
						wr_ptr_q <= rd_ptr_q;
						rd_ptr_q <= ptr_dec(rd_ptr_q);
						rem_q    <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= S_PLACE;
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FIN;
				end
				S_POP: begin
					res_key_q <= rdata_q[EW-1:PAY_W];
					res_pay_q <= rdata_q[PAY_W-1:0];
					head_q    <= ptr_inc(head_q);
					count_q   <= count_q - CW'(1);
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q      <= 1'b1;
						status_q         <= res_status_q;
						popped_key_q     <= res_key_q;
						popped_payload_q <= res_pay_q;
						entry_count_q    <= COUNT_OUT_W'(count_q);
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign popped_key     = popped_key_q;
	assign popped_payload = popped_payload_q;
	assign entry_count    = entry_count_q;

endmodule

// File: hw/rtl/skq_checker.sv
// port-level checks for the sorted key queue, bound to the top level
// depends on skq_pkg and sorted_key_queue_top
module skq_checker
	import skq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [STATUS_W-1:0]        status,
	input logic signed [KEY_W-1:0]    popped_key,
	input logic [PAY_W-1:0]           popped_payload,
	input logic [COUNT_OUT_W-1:0]     entry_count
);

	localparam logic [COUNT_OUT_W-1:0] CAP_OUT = COUNT_OUT_W'(CAPACITY);

	// a stalled result holds its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped_key)
			&& $stable(popped_payload) && $stable(entry_count))
		else $error("stalled result changed");

	// only ok results carry a popped entry
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> popped_key == '0 && popped_payload == '0)
		else $error("failed request carries entry data");

	// a dropped insert reports a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == CAP_OUT)
		else $error("full status with wrong count");

	// a pop on empty reports zero entries
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0)
		else $error("empty status with nonzero count");

	// no request is taken in the cycle right after another one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

endmodule

bind sorted_key_queue_top skq_checker #(.CAPACITY(CAPACITY)) u_skq_checker (.*);

// File: tb/sorted_key_queue_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted key queue: random insert/pop traffic with
// random stalls on both channels, checked against an in-bench sorted list model
// depends on skq_pkg and sorted_key_queue_top
module sorted_key_queue_top_tb;
	import skq_pkg::*;

	localparam int DEPTH          = CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 400;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]       payload;
		logic [COUNT_OUT_W-1:0] count;
	} queue_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       command = CMD_INSERT;
	logic signed [KEY_W-1:0]    item_key = '0;
	logic [PAY_W-1:0]           item_payload = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [STATUS_W-1:0]        status;
	logic signed [KEY_W-1:0]    popped_key;
	logic [PAY_W-1:0]           popped_payload;
	logic [COUNT_OUT_W-1:0]     entry_count;

	sorted_key_queue_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.item_key      (item_key),
		.item_payload  (item_payload),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.popped_key    (popped_key),
		.popped_payload(popped_payload),
		.entry_count   (entry_count)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model copy of the queue contents, ascending key order
	logic signed [KEY_W-1:0] model_keys [DEPTH];
	logic [PAY_W-1:0]        model_pays [DEPTH];
	int                      model_count = 0;

	queue_result_t pending_results [$];

	int  insert_count = 0;
	int  pop_count = 0;
	int  full_drop_count = 0;
	int  empty_pop_count = 0;
	int  result_count = 0;
	int  mismatch_count = 0;
	int  idle_cycles = 0;
	bit  quiet_mode = 1'b0;
	int  hold_request = 0;

	// apply one request to the model and return the result it should give
	function automatic queue_result_t apply_request(input logic cmd,
			input logic signed [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
		queue_result_t res;
		int pos;
		res = '0;
		res.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			insert_count++;
			if (model_count >= DEPTH) begin
				res.status = ST_FULL;
				full_drop_count++;
			end else begin
				// new entry goes ahead of the first key that is greater or equal
				pos = 0;
				while (pos < model_count && model_keys[pos] < key)
					pos++;
				for (int i = model_count; i > pos; i--) begin
					model_keys[i] = model_keys[i-1];
					model_pays[i] = model_pays[i-1];
				end
				model_keys[pos] = key;
				model_pays[pos] = pay;
				model_count++;
			end
		end else begin
			pop_count++;
			if (model_count == 0) begin
				res.status = ST_EMPTY;
				empty_pop_count++;
			end else begin
				res.key = model_keys[0];
				res.payload = model_pays[0];
				for (int i = 1; i < model_count; i++) begin
					model_keys[i-1] = model_keys[i];
					model_pays[i-1] = model_pays[i];
				end
				model_count--;
			end
		end
		res.count = model_count[COUNT_OUT_W-1:0];
		return res;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (quiet_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// keys: full range, a narrow band for ties, and the extremes
	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 15)) - 8;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// offer one request and wait for the block to take it
	task automatic send_request(input logic cmd, input logic signed [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		item_key <= key;
		item_payload <= pay;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(apply_request(cmd, key, pay));
	endtask

	task automatic send_insert(input logic signed [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
		send_request(CMD_INSERT, key, pay);
	endtask

	// pop carries junk in the unused fields
	task automatic send_pop();
		send_request(CMD_POP, $urandom, $urandom);
	endtask

	// stop offering until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// pop on empty, then the key extremes and both payload extremes, then pop until empty and once more
	task automatic test_empty_and_extremes();
		send_pop();
		send_insert(32'sh7fffffff, 32'hffffffff);
		send_insert(32'sh80000000, 32'h00000000);
		send_insert(32'sh0, 32'ha5a5a5a5);
		send_insert(-32'sd1, 32'h5a5a5a5a);
		send_insert(32'sd1, 32'h12345678);
		repeat (5) send_pop();
		send_pop();
		drain_results();
	endtask

	// equal keys: newest goes first, at the head and further down
	task automatic test_tie_ordering();
		send_insert(32'sd5, 32'd1);
		send_insert(32'sd5, 32'd2);
		send_insert(32'sd5, 32'd3);
		send_insert(32'sd3, 32'd4);
		send_insert(32'sd5, 32'd5);
		send_insert(32'sd9, 32'd6);
		repeat (6) send_pop();
		drain_results();
	endtask

	// fill past capacity so inserts drop, then empty it and pop twice more
	task automatic test_fill_to_capacity();
		repeat (DEPTH + 3) send_insert(pick_key(), $urandom);
		repeat (DEPTH + 2) send_pop();
		drain_results();
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_receiver_hold();
		hold_request = LONG_HOLD;
		quiet_mode = 1'b1;
		repeat (40) send_insert(pick_key(), $urandom);
		repeat (40) send_pop();
		quiet_mode = 1'b0;
		drain_results();
	endtask

	// mixed traffic in phases of different insert share to sweep the fill level
	task automatic test_random_traffic(input int phases, input int per_phase);
		int insert_pct;
		for (int p = 0; p < phases; p++) begin
			case (p % 6)
				0: insert_pct = 90;
				1: insert_pct = 70;
				2: insert_pct = 50;
				3: insert_pct = 30;
				4: insert_pct = 10;
				default: insert_pct = 60;
			endcase
			quiet_mode = (p % 4 == 3);
			for (int n = 0; n < per_phase; n++) begin
				if ($urandom_range(0, 99) < insert_pct)
					send_insert(pick_key(), $urandom);
				else
					send_pop();
			end
		end
		quiet_mode = 1'b0;
	endtask

	// result checker and receiver stall control
	initial begin : result_checker
		queue_result_t want;
		int stall_left;
		int gap;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				result_count++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result: status %0d key %0d payload %h count %0d",
							status, popped_key, popped_payload, entry_count);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || popped_key !== want.key ||
							popped_payload !== want.payload || entry_count !== want.count) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("mismatch at result %0d", result_count);
							$display("  expected status %0d key %0d payload %h count %0d",
								want.status, want.key, want.payload, want.count);
							$display("  actual   status %0d key %0d payload %h count %0d",
								status, popped_key, popped_payload, entry_count);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_request > 0) begin
				stall_left = hold_request - 1;
				hold_request = 0;
				out_ready <= 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					stall_left = gap - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no request and no result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_key_queue_top regression: fail");
			$finish;
		end
	end

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_tie_ordering();
		test_fill_to_capacity();
		test_receiver_hold();
		test_random_traffic(10, 150);

		drain_results();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			mismatch_count += pending_results.size();

		$display("ran %0d inserts (%0d dropped as full) and %0d pops (%0d on empty)",
			insert_count, full_drop_count, pop_count, empty_pop_count);
		$display("checked %0d results, one receiver hold of %0d cycles, %0d mismatches",
			result_count, LONG_HOLD, mismatch_count);
		if (mismatch_count == 0)
			$display("sorted_key_queue_top regression: pass");
		else
			$display("sorted_key_queue_top regression: fail");
		$finish;
	end

endmodule
